// ===== rtl/core/eps_pkg.sv =====
// Shared types and constants for the encoder period, speed and position block.
package eps_pkg;

	// Register indexes of the configuration port
	localparam logic REG_PULSES_PER_REV = 1'b0;
	localparam logic REG_TICK_RATE_HZ   = 1'b1;

	// Configuration values after reset
	localparam logic [15:0] PPR_RESET  = 16'd1;
	localparam logic [27:0] TICK_RESET = 28'd1000000;

	// Field widths
	localparam int unsigned CAP_W  = 16;
	localparam int unsigned IDX_W  = 16;
	localparam int unsigned POS_W  = 17;
	localparam int unsigned SPD_W  = 32;
	localparam int unsigned TICK_W = 28;

	// Dividend width: 15360 * tick rate stays below 2^42
	localparam int unsigned NUM_W = 42;

	// Scale factors: 360 degrees in Q8, and 60 s/min in Q8
	localparam logic [16:0] POS_SCALE = 17'd92160;
	localparam logic [13:0] SPD_SCALE = 14'd15360;

	localparam logic [SPD_W-1:0] SPEED_MAX = '1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_POS_GO,
		ST_POS_RUN,
		ST_SPD_GO,
		ST_SPD_RUN,
		ST_EMIT
	} seq_state_t;

	// Divider control and status
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== rtl/core/eps_div.sv =====
// Shared restoring divider: one quotient bit per cycle.
module eps_div #(
	parameter int unsigned NUM_W = 42,
	parameter int unsigned DEN_W = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  eps_pkg::div_ctl_t    ctl,
	input  logic [NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]     den,
	output eps_pkg::div_sts_t    sts,
	output logic [NUM_W-1:0]     quo
);
	import eps_pkg::*;

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;
	logic             ge;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		ge    = ~diff[DEN_W+1];
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (ctl.start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Operands, partial remainder and quotient
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign quo      = quo_q;

endmodule

// ===== rtl/core/encoder_period_speed_position_top.sv =====
// Top level: capture state, sequencer and result register around the shared divider.
//
//  channel  | signals                              | direction | content
//  ---------+--------------------------------------+-----------+----------------------------
//  s        | s_tvalid s_tready s_tdata[15:0]       | in        | capture timestamp
//  m        | m_tvalid m_tready m_tdata m_tuser     | out       | period, index, position, speed
//  cfg      | cfg_we cfg_index cfg_wdata[27:0]      | in        | register write, no wait
//
//  A pulse uses the 42-bit restoring divider once for the position and, when the period is
//  nonzero, once more for the speed; the divider yields one quotient bit per cycle.
//  s_tready is high only while the sequencer is idle; a result in the output register does not block it.
//  A finished result waits in its state until the output register is free.
//  Reset clears the capture, the pulse index and the registers to their reset values.
module encoder_period_speed_position_top #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // capture_time[15:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // period_ticks[15:0], position_index[31:16],
	                               // position_deg_q8[48:32], speed_rpm_q8[80:49], pad[87:81]
	output logic [0:0]  m_tuser,   // zero_period[0]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [27:0] cfg_wdata
);
	import eps_pkg::*;

	localparam int unsigned TB    = TIMER_BITS;
	localparam int unsigned DEN_W = IDX_W + TB;

	// Configuration
	logic [15:0]       ppr_q;
	logic [TICK_W-1:0] tick_q;

	// Pulse state and working registers
	logic [TB-1:0]     last_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TB-1:0]     period_q;
	logic              zero_q;
	logic [NUM_W-1:0]  pos_num_q;
	logic [NUM_W-1:0]  spd_num_q;
	logic [DEN_W-1:0]  spd_den_q;
	logic [POS_W-1:0]  pos_q;
	logic [SPD_W-1:0]  spd_q;

	// Result register
	logic              m_tvalid_q;
	logic [87:0]       m_tdata_q;
	logic              m_tuser_q;

	seq_state_t        state_q, state_d;
	div_ctl_t          div_ctl;
	div_sts_t          div_sts;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [NUM_W-1:0]  div_quo;

	logic              s_acc;
	logic              out_free;
	logic [15:0]       n_eff;
	logic [IDX_W-1:0]  idx_next;
	logic [TB+CAP_W-1:0] cap_wide;
	logic [TB-1:0]     cur;
	logic [TB+16-1:0]  period_wide;
	logic [32:0]       pos_prod;

	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// Fit the capture to the timer width
	assign cap_wide = {{TB{1'b0}}, s_tdata};
	assign cur      = cap_wide[TB-1:0];

	// Treat zero pulses per revolution as one, and wrap the index at N
	assign n_eff    = (ppr_q == 16'd0) ? 16'd1 : ppr_q;
	assign idx_next = (idx_q >= n_eff) ? IDX_W'(1) : idx_q + IDX_W'(1);

	assign pos_prod    = 33'(idx_q) * 33'(POS_SCALE);
	assign period_wide = {16'd0, period_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q  <= PPR_RESET;
			tick_q <= TICK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PULSES_PER_REV: ppr_q  <= cfg_wdata[15:0];
				REG_TICK_RATE_HZ:   tick_q <= cfg_wdata;
			endcase
		end
	end

	// Capture and index state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			idx_q  <= '0;
		end else if (s_acc) begin
			last_q <= cur;
			idx_q  <= idx_next;
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider control
	always_comb begin
		state_d       = state_q;
		div_ctl.start = 1'b0;
		div_num       = pos_num_q;
		div_den       = {{TB{1'b0}}, n_eff};
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) state_d = ST_PREP;
			end
			ST_PREP: begin
				state_d = ST_POS_GO;
			end
			ST_POS_GO: begin
				div_ctl.start = 1'b1;
				state_d       = ST_POS_RUN;
			end
			ST_POS_RUN: begin
				if (div_sts.done) state_d = zero_q ? ST_EMIT : ST_SPD_GO;
			end
			ST_SPD_GO: begin
				div_ctl.start = 1'b1;
				div_num       = spd_num_q;
				div_den       = spd_den_q;
				state_d       = ST_SPD_RUN;
			end
			ST_SPD_RUN: begin
				div_num = spd_num_q;
				div_den = spd_den_q;
				if (div_sts.done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			period_q <= cur - last_q;
			zero_q   <= (cur == last_q);
		end
		if (state_q == ST_PREP) begin
			pos_num_q <= NUM_W'(pos_prod);
			spd_num_q <= NUM_W'(tick_q) * NUM_W'(SPD_SCALE);
			spd_den_q <= DEN_W'(n_eff) * DEN_W'(period_q);
			spd_q     <= SPEED_MAX;
		end
		if (state_q == ST_POS_RUN && div_sts.done) begin
			pos_q <= div_quo[POS_W-1:0];
		end
		if (state_q == ST_SPD_RUN && div_sts.done) begin
			spd_q <= (div_quo[NUM_W-1:SPD_W] != '0) ? SPEED_MAX : div_quo[SPD_W-1:0];
		end
	end

	// Result register: load when free, drop on a taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= {7'd0, spd_q, pos_q, idx_q, period_wide[15:0]};
			m_tuser_q <= zero_q;
		end
	end

	eps_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.num    (div_num),
		.den    (div_den),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule

// ===== rtl/core/eps_checker.sv =====
// Port-level checks for the encoder period, speed and position block, with its bind.
module eps_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// Hold a result beat until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped before it was taken");

	// Work on one pulse at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again while a pulse is in work");

	// A new result only comes out of a busy sequencer
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a pulse in work");

	// A zero period always reports saturated speed
	a_zero_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[80:49] == 32'hFFFFFFFF)
		else $error("zero period without saturated speed");

	// The pulse index never reads zero
	a_index_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:16] != 16'd0)
		else $error("pulse index of zero reported");

endmodule

bind encoder_period_speed_position_top eps_port_props u_eps_port_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== test/eps_checker.sv =====
// Checker for the encoder period, speed and position block: predicts each pulse and compares.
`timescale 1ns / 1ps

module eps_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // capture_time[15:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [87:0] m_tdata,   // period_ticks[15:0], position_index[31:16],
	                               // position_deg_q8[48:32], speed_rpm_q8[80:49], pad[87:81]
	input  logic [0:0]  m_tuser,   // zero_period[0]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [27:0] cfg_wdata,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	import eps_pkg::*;

	// One full turn in Q8 degrees, and seconds per minute in Q8
	localparam logic [63:0] DEG_Q8_PER_TURN = 64'd360 * 64'd256;
	localparam logic [63:0] RPM_Q8_PER_HZ   = 64'd60 * 64'd256;

	typedef struct packed {
		logic [15:0] period;
		logic [15:0] index;
		logic [16:0] deg_q8;
		logic [31:0] rpm_q8;
		logic        zero;
	} pulse_result_t;

	pulse_result_t pulse_results_q[$];

	// Shadow of the registers and the pulse state
	logic [15:0] ppr_shadow;
	logic [27:0] tick_hz_shadow;
	logic [15:0] prev_capture;
	logic [15:0] prev_index;
	int unsigned fail_cnt;
	int unsigned result_no;

	// Work out the beat expected for one capture, from the state before it
	function automatic pulse_result_t predict_pulse(input logic [15:0] capture);
		pulse_result_t r;
		logic [63:0] n;
		logic [63:0] quot;
		n = (ppr_shadow == '0) ? 64'd1 : 64'(ppr_shadow);
		r.period = capture - prev_capture;
		r.index = (64'(prev_index) >= n) ? 16'd1 : prev_index + 16'd1;
		r.deg_q8 = 17'((64'(r.index) * DEG_Q8_PER_TURN) / n);
		r.zero = (r.period == '0);
		if (r.zero) begin
			r.rpm_q8 = '1;
		end else begin
			quot = (RPM_Q8_PER_HZ * 64'(tick_hz_shadow)) / (n * 64'(r.period));
			r.rpm_q8 = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
		end
		return r;
	endfunction

	task automatic note_failure(input string msg);
		if (fail_cnt < 10)
			$display("mismatch at result %0d: %s", result_no, msg);
		fail_cnt++;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
	                           input logic [63:0] got);
		if (want !== got)
			note_failure($sformatf("%s expected %0h, got %0h", name, want, got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		pulse_result_t want;
		if (!arst_n) begin
			pulse_results_q.delete();
			ppr_shadow = 16'd1;
			tick_hz_shadow = 28'd1000000;
			prev_capture = '0;
			prev_index = '0;
			fail_cnt = 0;
			result_no = 0;
		end else begin
			// Compare an outgoing beat with the oldest prediction
			if (m_tvalid && m_tready) begin
				if (pulse_results_q.size() == 0) begin
					note_failure("result beat with no pulse pending");
				end else begin
					want = pulse_results_q.pop_front();
					check_field("period_ticks", want.period, m_tdata[15:0]);
					check_field("position_index", want.index, m_tdata[31:16]);
					check_field("position_deg_q8", want.deg_q8, m_tdata[48:32]);
					check_field("speed_rpm_q8", want.rpm_q8, m_tdata[80:49]);
					check_field("tdata padding", '0, m_tdata[87:81]);
					check_field("zero_period", want.zero, m_tuser[0]);
				end
				result_no++;
			end
			// Track register writes
			if (cfg_we) begin
				if (cfg_index == REG_PULSES_PER_REV)
					ppr_shadow = cfg_wdata[15:0];
				else if (cfg_index == REG_TICK_RATE_HZ)
					tick_hz_shadow = cfg_wdata;
			end
			// Predict an accepted capture and advance the state
			if (s_tvalid && s_tready) begin
				want = predict_pulse(s_tdata);
				pulse_results_q.push_back(want);
				prev_capture = s_tdata;
				prev_index = want.index;
			end
		end
		mismatches <= fail_cnt;
		outstanding <= pulse_results_q.size();
	end

endmodule

// ===== test/tb.sv =====
// Testbench top: clock, reset, capture stimulus, register writes and the verdict.
`timescale 1ns / 1ps

module tb;
	import eps_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 120;
	localparam int unsigned QUIET_LIMIT   = 5000;
	localparam int unsigned BLOCK_ITEMS   = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_PULSES_PER_REV;
	logic [27:0] cfg_wdata = '0;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned src_idle = 0;
	int unsigned sink_stall = 0;
	int unsigned quiet_cycles = 0;
	logic [15:0] last_capture = '0;

	encoder_period_speed_position_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	eps_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= sink_stall);
	end

	// End the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one capture, with random gaps ahead of it, and hold it until taken
	task automatic send_capture(input logic [15:0] capture);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= capture;
		last_capture = capture;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid, wait for every pending result, then let the divider finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(input logic [27:0] ppr, input logic [27:0] tick_hz);
		cfg_we <= 1'b1;
		cfg_index <= REG_PULSES_PER_REV;
		cfg_wdata <= ppr;
		@(posedge clk);
		cfg_index <= REG_TICK_RATE_HZ;
		cfg_wdata <= tick_hz;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly plausible periods, with repeats, wraps and arbitrary jumps mixed in
	function automatic logic [15:0] next_capture(input logic [15:0] prev);
		case ($urandom_range(9))
			0: return prev;
			1: return prev + 16'd1;
			2: return prev - 16'd1;
			3: return 16'($urandom);
			default: return prev + 16'($urandom_range(2, 4000));
		endcase
	endfunction

	task automatic random_config();
		logic [27:0] ppr;
		logic [27:0] tick_hz;
		case ($urandom_range(7))
			0: ppr = 28'd1;
			1: ppr = 28'd0;
			2: ppr = 28'hFFFF;
			3, 4, 5: ppr = 28'($urandom_range(2, 12));
			6: ppr = 28'($urandom_range(13, 65535));
			default: ppr = 28'($urandom);
		endcase
		case ($urandom_range(5))
			0: tick_hz = 28'd1;
			1: tick_hz = 28'hFFF_FFFF;
			2: tick_hz = 28'd0;
			3: tick_hz = 28'd200000000;
			default: tick_hz = 28'($urandom_range(1, 200000000));
		endcase
		write_config(ppr, tick_hz);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: zero period on the first pulse, wrap of the timer
		send_capture(16'h0000);
		send_capture(16'h0001);
		send_capture(16'hFFFF);
		send_capture(16'h0000);
		send_capture(16'h0000);
		settle();

		// Largest pulse count and tick rate, periods up to 0xFFFE
		write_config(28'hFFFF, 28'hFFF_FFFF);
		send_capture(16'h0001);
		send_capture(16'h8001);
		send_capture(16'h7FFF);
		settle();

		// Speed overflow: one pulse per turn, fastest clock, period of one tick
		write_config(28'd1, 28'hFFF_FFFF);
		send_capture(16'h8000);
		send_capture(16'h8001);
		send_capture(16'h8001);
		settle();

		// Pulse count of zero acts as one; tick rate of zero gives no speed
		write_config(28'd0, 28'd0);
		send_capture(16'h1234);
		send_capture(16'h1234);
		send_capture(16'hABCD);
		settle();

		// Upper write bits beyond the pulse count are dropped; run the index up
		write_config(28'hABC0007, 28'd1);
		for (int i = 1; i <= 6; i++)
			send_capture(16'(i * 16'h1111));
		settle();

		// Lower the pulse count below the index so that it wraps at once
		write_config(28'd3, 28'd200000000);
		send_capture(16'hF0F0);
		send_capture(16'h0F0F);
		settle();

		// Random part over the idling phases, with fresh settings per block
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle = 0; sink_stall = 0; end
				1: begin src_idle = 65; sink_stall = 0; end
				2: begin src_idle = 0; sink_stall = 65; end
				default: begin src_idle = 35; sink_stall = 35; end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				random_config();
				repeat (BLOCK_ITEMS)
					send_capture(next_capture(last_capture));
				settle();
			end
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
